/* src/uslf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uslf_pkg: shared types and constants for the UDP sender lock filter
// Field widths, command and status codes, TS slicing constants, and the
// structs passed between the filter core and the payload slicer.
// ----------------------------------------------------------------------------
package uslf_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF  = 8;
  localparam int MAX_DATAGRAM_DEF = 1460;

  // At most this many senders come out of one list command
  localparam int MAX_LIST = 8;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int LEN_W    = 11;
  localparam int BYTE_W   = 8;
  localparam int EXT_W    = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 4;
  localparam int OFF_W    = 19;
  localparam int PKTCNT_W = 3;
  localparam int TRAIL_W  = 8;

  // RTP / TS framing
  localparam int RTP_HDR_BYTES     = 12;
  localparam int RTP_EXT_HDR_BYTES = 4;
  localparam int RTP_EXT_BIT       = 4;
  localparam int EXT_MIN_LEN       = RTP_HDR_BYTES + RTP_EXT_HDR_BYTES;
  localparam int TS_PKT_BYTES      = 188;

  // Divide by 188 via reciprocal; exact for every 11-bit dividend
  localparam int DIV_SHIFT = 20;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + TS_PKT_BYTES - 1) / TS_PKT_BYTES;
  localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
  localparam int PROD_W    = LEN_W + RECIP_W;
  localparam int QUO_W     = $clog2((2 ** LEN_W) / TS_PKT_BYTES + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_DATAGRAM = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARDED  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 4'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT_EXT  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_OK         = 4'd4;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NO_SOURCE  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_ENTRY      = 4'd7;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd8;

  // One sender table word
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] seen;
  } entry_t;

  // Slicer results toward the core
  typedef struct packed {
    logic [OFF_W-1:0]    offset;
    logic [PKTCNT_W-1:0] count;
    logic [TRAIL_W-1:0]  trailing;
    logic                fmt_err;
    logic                short_ext;
  } slice_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [PKTCNT_W-1:0] count;
    logic [TRAIL_W-1:0]  trailing;
    logic                fmt_err;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [TIME_W-1:0]   seen;
    logic                known;
    logic                last;
  } result_t;

  // Core sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESULT,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

endpackage

/* src/uslf_slicer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uslf_slicer: RTP skip and TS packet slicing
// Two-stage arithmetic on a held datagram header: payload offset, whole
// 188-byte packet count, trailing bytes and boundary error.
// ----------------------------------------------------------------------------
module uslf_slicer (
  input  logic                            clk,
  input  logic                            rtp_enable,
  input  logic [uslf_pkg::LEN_W-1:0]      length,
  input  logic                            ext_flag,
  input  logic [uslf_pkg::EXT_W-1:0]      ext_words,
  output uslf_pkg::slice_t                slice
);

  logic [uslf_pkg::OFF_W-1:0]  off_c;
  logic                        short_c;
  logic                        gt_c;
  logic                        eq_c;
  logic [uslf_pkg::LEN_W-1:0]  diff_c;
  logic [uslf_pkg::PROD_W-1:0] prod_c;

  logic [uslf_pkg::OFF_W-1:0]  off_r;
  logic                        short_r;
  logic                        gt_r;
  logic                        eq_r;
  logic [uslf_pkg::LEN_W-1:0]  diff_r;
  logic [uslf_pkg::QUO_W-1:0]  quo_r;

  logic [uslf_pkg::LEN_W-1:0]  end_part;
  logic [uslf_pkg::LEN_W-1:0]  rem;

  // Stage 1: offset, compare, reciprocal multiply
  always_comb begin
    off_c = '0;
    if (rtp_enable) begin
      off_c = uslf_pkg::OFF_W'(uslf_pkg::RTP_HDR_BYTES);
      if (ext_flag) begin
        off_c = off_c + uslf_pkg::OFF_W'({ext_words, 2'b00})
              + uslf_pkg::OFF_W'(uslf_pkg::RTP_EXT_HDR_BYTES);
      end
    end
  end

  assign short_c = rtp_enable && ext_flag
                && (length < uslf_pkg::LEN_W'(uslf_pkg::EXT_MIN_LEN));
  assign gt_c    = uslf_pkg::OFF_W'(length) > off_c;
  assign eq_c    = uslf_pkg::OFF_W'(length) == off_c;
  // Only meaningful when the offset lies below the length
  assign diff_c  = length - off_c[uslf_pkg::LEN_W-1:0];
  assign prod_c  = uslf_pkg::PROD_W'(diff_c) * uslf_pkg::PROD_W'(uslf_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    off_r   <= off_c;
    short_r <= short_c;
    gt_r    <= gt_c;
    eq_r    <= eq_c;
    diff_r  <= diff_c;
    quo_r   <= prod_c[uslf_pkg::DIV_SHIFT +: uslf_pkg::QUO_W];
  end

  // Stage 2: remainder
  assign end_part = uslf_pkg::LEN_W'(quo_r) * uslf_pkg::LEN_W'(uslf_pkg::TS_PKT_BYTES);
  assign rem      = diff_r - end_part;

  always_comb begin
    slice.offset    = off_r;
    slice.short_ext = short_r;
    if (gt_r) begin
      slice.count    = quo_r[uslf_pkg::PKTCNT_W-1:0];
      slice.trailing = rem[uslf_pkg::TRAIL_W-1:0];
      slice.fmt_err  = (rem != '0);
    end else begin
      // Offset at or past the end: nothing sliced
      slice.count    = '0;
      slice.trailing = '0;
      slice.fmt_err  = !eq_r;
    end
  end

endmodule

/* src/udp_sender_lock_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_sender_lock_filter_core: UDP sender table and source lock filter
// Tracks datagram senders in a small ring memory, holds a source lock, and
// slices forwarded datagrams into TS packets; commands manage the lock and the table.
// ----------------------------------------------------------------------------
// Sequence: an item is taken only in idle. Datagram and set scan the table (a hit
//   ends the scan early) and then update it; query scans only; clear, reject
//   and ignored go straight to the result; list reads and sends each entry in
//   turn, at most MAX_LIST of them. A new item is not taken until the last result has been loaded.
// Reset: synchronous; clears lock, fill count, ring pointer and rtp_enable.
//   Table memory is not cleared: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module udp_sender_lock_filter_core #(
  parameter int TABLE_DEPTH  = uslf_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_DATAGRAM = uslf_pkg::MAX_DATAGRAM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [uslf_pkg::CMD_W-1:0]         command,
  input  logic [uslf_pkg::ADDR_W-1:0]        src_addr,
  input  logic [uslf_pkg::PORT_W-1:0]        src_port,
  input  logic [uslf_pkg::LEN_W-1:0]         length,
  input  logic [uslf_pkg::BYTE_W-1:0]        rtp_first_byte,
  input  logic [uslf_pkg::EXT_W-1:0]         ext_length_words,
  input  logic [uslf_pkg::TIME_W-1:0]        now_seconds,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [uslf_pkg::STATUS_W-1:0]      status,
  output logic [uslf_pkg::OFF_W-1:0]         payload_offset,
  output logic [uslf_pkg::PKTCNT_W-1:0]      packet_count,
  output logic [uslf_pkg::TRAIL_W-1:0]       trailing_bytes,
  output logic                               format_error,
  output logic [uslf_pkg::ADDR_W-1:0]        entry_addr,
  output logic [uslf_pkg::PORT_W-1:0]        entry_port,
  output logic [uslf_pkg::TIME_W-1:0]        entry_last_seen,
  output logic                               entry_seen_known,
  output logic                               last_result
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  uslf_pkg::state_t state, state_next;

  logic                          rtp_enable;
  logic [CNT_W-1:0]              entry_count;
  logic [IDX_W-1:0]              oldest_slot;
  logic                          lock_valid;
  logic [uslf_pkg::ADDR_W-1:0]   lock_addr;
  logic [uslf_pkg::PORT_W-1:0]   lock_port;

  // Held item
  logic [uslf_pkg::CMD_W-1:0]    cmd_r;
  logic [uslf_pkg::ADDR_W-1:0]   key_addr;
  logic [uslf_pkg::PORT_W-1:0]   key_port;
  logic [uslf_pkg::LEN_W-1:0]    len_r;
  logic                          ext_flag_r;
  logic [uslf_pkg::EXT_W-1:0]    ext_words_r;
  logic [uslf_pkg::TIME_W-1:0]   now_r;
  logic                          scan_en;

  // Scan / list walk
  logic [CNT_W-1:0]              k_issue;
  logic                          rd_pending;
  logic [IDX_W-1:0]              rd_slot;
  logic                          found;
  logic [IDX_W-1:0]              found_slot;
  logic [uslf_pkg::TIME_W-1:0]   found_seen;

  // Sender table: one write port, one registered read port
  uslf_pkg::entry_t              tbl_mem [TABLE_DEPTH];
  uslf_pkg::entry_t              rd_data;
  uslf_pkg::entry_t              wr_data;
  logic                          mem_re;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_rd_idx;
  logic [IDX_W-1:0]              mem_wr_idx;

  // Output register
  uslf_pkg::result_t             out_r;
  uslf_pkg::result_t             res_next;
  logic                          out_vld;

  // Control
  logic                          in_fire;
  logic                          out_free;
  logic                          load_out;
  logic                          scan_issue;
  logic                          scan_more;
  logic                          key_hit;
  logic                          do_update;
  logic                          do_refresh;
  logic                          list_step;
  logic                          list_last;
  logic                          table_full;
  logic [IDX_W-1:0]              issue_slot;
  logic [IDX_W-1:0]              ins_slot;
  logic [uslf_pkg::LEN_W-1:0]    len_clamped;
  uslf_pkg::slice_t              slice;

  // Ring position base + k, both below TABLE_DEPTH
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] k);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (IDX_W + 1)'(TABLE_DEPTH)) begin
      s = s - (IDX_W + 1)'(TABLE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Payload slicer, registered after its stage 1, works off the header held at accept
  // ---------------------------------------------------------------------------
  uslf_slicer u_slicer (
    .clk        (clk),
    .rtp_enable (rtp_enable),
    .length     (len_r),
    .ext_flag   (ext_flag_r),
    .ext_words  (ext_words_r),
    .slice      (slice)
  );

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_vld || out_ready;

  // Oversize datagrams are taken as the maximum size
  assign len_clamped = (32'(length) > 32'(MAX_DATAGRAM)) ? uslf_pkg::LEN_W'(MAX_DATAGRAM)
                                                         : length;

  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign scan_more  = scan_en && (k_issue < entry_count);
  assign issue_slot = ring_slot(oldest_slot, k_issue[IDX_W-1:0]);
  assign key_hit    = rd_pending && (rd_data.addr == key_addr) && (rd_data.port == key_port);

  // Refresh target: the matching slot, else evict oldest when full, else append
  assign ins_slot = found      ? found_slot :
                    table_full ? oldest_slot :
                                 ring_slot(oldest_slot, entry_count[IDX_W-1:0]);

  // Datagrams from the unknown address 0 never enter the table
  assign do_refresh = (cmd_r == uslf_pkg::CMD_DATAGRAM) ? (key_addr != '0)
                                                        : (cmd_r == uslf_pkg::CMD_SET);

  assign list_last = (32'(k_issue) + 32'd1 == 32'(entry_count))
                  || (32'(k_issue) + 32'd1 == 32'(uslf_pkg::MAX_LIST));

  assign wr_data.addr = key_addr;
  assign wr_data.port = key_port;
  assign wr_data.seen = now_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      uslf_pkg::S_IDLE: begin
        if (in_valid) begin
          case (command)
            uslf_pkg::CMD_DATAGRAM: begin
              state_next = (length == '0) ? uslf_pkg::S_RESULT : uslf_pkg::S_SCAN;
            end
            uslf_pkg::CMD_SET: begin
              state_next = (src_addr == '0 || src_port == '0) ? uslf_pkg::S_RESULT
                                                              : uslf_pkg::S_SCAN;
            end
            uslf_pkg::CMD_QUERY: begin
              state_next = lock_valid ? uslf_pkg::S_SCAN : uslf_pkg::S_RESULT;
            end
            uslf_pkg::CMD_LIST: begin
              state_next = (entry_count != '0) ? uslf_pkg::S_LIST_RD : uslf_pkg::S_RESULT;
            end
            default: begin
              state_next = uslf_pkg::S_RESULT;
            end
          endcase
        end
      end
      uslf_pkg::S_SCAN: begin
        if (key_hit || !scan_more) begin
          state_next = (cmd_r == uslf_pkg::CMD_QUERY) ? uslf_pkg::S_RESULT
                                                      : uslf_pkg::S_UPDATE;
        end
      end
      uslf_pkg::S_UPDATE: begin
        state_next = uslf_pkg::S_RESULT;
      end
      uslf_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = uslf_pkg::S_IDLE;
        end
      end
      uslf_pkg::S_LIST_RD: begin
        state_next = uslf_pkg::S_LIST_OUT;
      end
      uslf_pkg::S_LIST_OUT: begin
        if (out_free) begin
          state_next = list_last ? uslf_pkg::S_IDLE : uslf_pkg::S_LIST_RD;
        end
      end
      default: begin
        state_next = uslf_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    mem_re     = 1'b0;
    mem_rd_idx = issue_slot;
    mem_we     = 1'b0;
    mem_wr_idx = ins_slot;
    do_update  = 1'b0;
    load_out   = 1'b0;
    list_step  = 1'b0;
    case (state)
      uslf_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      uslf_pkg::S_SCAN: begin
        // Pipelined walk: issue the next read while comparing the last one
        scan_issue = !key_hit && scan_more;
        mem_re     = scan_issue;
      end
      uslf_pkg::S_UPDATE: begin
        do_update = 1'b1;
        mem_we    = do_refresh;
      end
      uslf_pkg::S_RESULT: begin
        load_out = out_free;
      end
      uslf_pkg::S_LIST_RD: begin
        mem_re = 1'b1;
      end
      uslf_pkg::S_LIST_OUT: begin
        load_out  = out_free;
        list_step = out_free && !list_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uslf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender table memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wr_idx] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= tbl_mem[mem_rd_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers: config, fill count, ring pointer, lock, walk
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_enable  <= 1'b0;
      entry_count <= '0;
      oldest_slot <= '0;
      lock_valid  <= 1'b0;
      lock_addr   <= '0;
      lock_port   <= '0;
      k_issue     <= '0;
      rd_pending  <= 1'b0;
      found       <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rtp_enable <= cfg_data;
      end

      if (in_fire) begin
        k_issue    <= '0;
        rd_pending <= 1'b0;
        found      <= 1'b0;
        if (command == uslf_pkg::CMD_CLEAR) begin
          lock_valid <= 1'b0;
          lock_addr  <= '0;
          lock_port  <= '0;
        end
      end

      if (state == uslf_pkg::S_SCAN) begin
        rd_pending <= scan_issue;
        if (scan_issue) begin
          k_issue <= k_issue + CNT_W'(1);
        end
        if (key_hit) begin
          found <= 1'b1;
        end
      end

      if (do_update && do_refresh) begin
        // New sender: advance the ring when evicting, else grow the fill count
        if (!found) begin
          if (table_full) begin
            oldest_slot <= (oldest_slot == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                   : oldest_slot + IDX_W'(1);
          end else begin
            entry_count <= entry_count + CNT_W'(1);
          end
        end
        // Set always locks; a datagram locks only when no lock is held
        if (cmd_r == uslf_pkg::CMD_SET || !lock_valid) begin
          lock_valid <= 1'b1;
          lock_addr  <= key_addr;
          lock_port  <= key_port;
        end
      end

      if (list_step) begin
        k_issue <= k_issue + CNT_W'(1);
      end

      if (load_out) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= command;
      key_addr    <= (command == uslf_pkg::CMD_QUERY) ? lock_addr : src_addr;
      key_port    <= (command == uslf_pkg::CMD_QUERY) ? lock_port : src_port;
      len_r       <= len_clamped;
      ext_flag_r  <= rtp_first_byte[uslf_pkg::RTP_EXT_BIT];
      ext_words_r <= ext_length_words;
      now_r       <= now_seconds;
      // Query searches for the lock; address 0 datagrams skip the table
      scan_en     <= (command != uslf_pkg::CMD_DATAGRAM) || (src_addr != '0);
    end
    if (state == uslf_pkg::S_SCAN && scan_issue) begin
      rd_slot <= issue_slot;
    end
    if (state == uslf_pkg::S_SCAN && key_hit) begin
      found_slot <= rd_slot;
      found_seen <= rd_data.seen;
    end
    if (load_out) begin
      out_r <= res_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result formation
  // ---------------------------------------------------------------------------
  always_comb begin
    res_next      = '0;
    res_next.last = 1'b1;
    if (state == uslf_pkg::S_LIST_OUT) begin
      res_next.status = uslf_pkg::ST_ENTRY;
      res_next.addr   = rd_data.addr;
      res_next.port   = rd_data.port;
      res_next.seen   = rd_data.seen;
      res_next.known  = 1'b1;
      res_next.last   = list_last;
    end else begin
      case (cmd_r)
        uslf_pkg::CMD_DATAGRAM: begin
          if (len_r == '0) begin
            res_next.status = uslf_pkg::ST_IGNORED;
          end else if (lock_valid && (lock_addr != key_addr || lock_port != key_port)) begin
            res_next.status = uslf_pkg::ST_NOT_ACTIVE;
          end else if (slice.short_ext) begin
            res_next.status = uslf_pkg::ST_SHORT_EXT;
          end else begin
            res_next.status   = uslf_pkg::ST_FORWARDED;
            res_next.offset   = slice.offset;
            res_next.count    = slice.count;
            res_next.trailing = slice.trailing;
            res_next.fmt_err  = slice.fmt_err;
          end
        end
        uslf_pkg::CMD_SET: begin
          res_next.status = (key_addr == '0 || key_port == '0) ? uslf_pkg::ST_REJECTED
                                                               : uslf_pkg::ST_OK;
        end
        uslf_pkg::CMD_CLEAR: begin
          res_next.status = uslf_pkg::ST_OK;
        end
        uslf_pkg::CMD_QUERY: begin
          if (!lock_valid) begin
            res_next.status = uslf_pkg::ST_NO_SOURCE;
          end else begin
            res_next.status = uslf_pkg::ST_ENTRY;
            res_next.addr   = lock_addr;
            res_next.port   = lock_port;
            res_next.seen   = found ? found_seen : '0;
            res_next.known  = found;
          end
        end
        uslf_pkg::CMD_LIST: begin
          // Only reached with an empty table
          res_next.status = uslf_pkg::ST_EMPTY;
        end
        default: begin
          res_next.status = uslf_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  assign out_valid        = out_vld;
  assign status           = out_r.status;
  assign payload_offset   = out_r.offset;
  assign packet_count     = out_r.count;
  assign trailing_bytes   = out_r.trailing;
  assign format_error     = out_r.fmt_err;
  assign entry_addr       = out_r.addr;
  assign entry_port       = out_r.port;
  assign entry_last_seen  = out_r.seen;
  assign entry_seen_known = out_r.known;
  assign last_result      = out_r.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("sender table fill count overflow");

  // The ring only rotates once the table is full
  a_ring_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_slot != '0) |-> table_full)
    else $error("ring pointer moved before table filled");

  // A held lock never names the unknown address
  a_lock_addr: assert property (@(posedge clk) disable iff (rst)
    lock_valid |-> (lock_addr != '0))
    else $error("lock held on address 0");

  // A pending non-final result only exists inside a list walk
  a_list_walk: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_r.last) |-> (state == uslf_pkg::S_LIST_RD || state == uslf_pkg::S_LIST_OUT))
    else $error("non-final result outside list walk");

endmodule
